/* rtl/lsaf_pkg.sv */
// Shared types and constants for the logical/shift/rotate ALU with flags.
// Holds the item structs, operation and size codes and flag bit masks.
// No dependencies.
package lsaf_pkg;

    localparam int NUM_DATA_REGS = 8;
    localparam int REG_IDX_W     = $clog2(NUM_DATA_REGS);

    localparam logic [3:0] ACT_AND = 4'd0;
    localparam logic [3:0] ACT_OR  = 4'd1;
    localparam logic [3:0] ACT_EOR = 4'd2;
    localparam logic [3:0] ACT_NOT = 4'd3;
    localparam logic [3:0] ACT_NEG = 4'd4;
    localparam logic [3:0] ACT_CLR = 4'd5;
    localparam logic [3:0] ACT_TST = 4'd6;
    localparam logic [3:0] ACT_ASL = 4'd7;
    localparam logic [3:0] ACT_ASR = 4'd8;
    localparam logic [3:0] ACT_LSL = 4'd9;
    localparam logic [3:0] ACT_LSR = 4'd10;
    localparam logic [3:0] ACT_ROL = 4'd11;
    localparam logic [3:0] ACT_ROR = 4'd12;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;

    localparam logic [3:0] FLAG_N = 4'h8;
    localparam logic [3:0] FLAG_Z = 4'h4;
    localparam logic [3:0] FLAG_V = 4'h2;
    localparam logic [3:0] FLAG_C = 4'h1;

    typedef struct packed {
        logic [3:0]  action;
        logic [1:0]  size_code;
        logic [31:0] source_operand;
        logic [31:0] dest_operand;
        logic        dest_is_register;
        logic [2:0]  dest_register;
        logic [23:0] dest_address;
        logic [7:0]  instr_cycles;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  flags_nzvc;
        logic        reg_written;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [23:0] mem_address;
        logic [31:0] mem_value;
        logic [1:0]  mem_size_code;
        logic [31:0] cycle_total;
    } out_item_t;

endpackage

/* rtl/logic_shift_alu_flags_top.sv */
// Top level of the 68000-style logical/shift/rotate execute stage.
// Depends on lsaf_pkg for item structs and codes.
//
//   channel | ports                     | payload
//   --------+---------------------------+-----------
//   input   | s_valid, s_ready, s_item  | in_item_t
//   result  | m_valid, m_ready, m_item  | out_item_t
//
// One item per cycle unless m_ready stalls; items pass stage A, then the m_valid register.
// Data registers sit in a synchronous RAM read at accept; a write back in the
// same cycle to the register being read is forwarded, so no bubble is needed.
// Reset clears the per-entry valid bits at once (entries read as zero), the
// flags and the cycle total. A stall on m_ready backs up through both stages.
module logic_shift_alu_flags_top
    import lsaf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // register file storage
    logic [31:0]              regs_mem [NUM_DATA_REGS];
    logic [NUM_DATA_REGS-1:0] regs_valid_reg;

    logic                     a_valid_reg;
    in_item_t                 a_item_reg;
    logic [31:0]              rd_data_reg;
    logic                     rd_valid_reg;
    logic                     fwd_hit_reg;
    logic [31:0]              fwd_data_reg;

    logic [3:0]               flags_reg;
    logic [31:0]              cycles_reg;

    logic                     m_valid_reg;
    out_item_t                m_item_reg;

    logic                     s_fire;
    logic                     a_adv;
    logic [REG_IDX_W-1:0]     s_idx;
    logic [REG_IDX_W-1:0]     a_idx;

    // stage A datapath
    logic [31:0] mask, msb_mask, src, d, res, old_val, merged;
    logic [5:0]  cnt, width, rot_e;
    logic [1:0]  sz_eff;
    logic [31:0] tmp;
    logic        cy, ov, writes, reg_wr, in_range;
    logic [3:0]  fl;
    out_item_t   out_next;

    assign a_adv   = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !a_valid_reg || a_adv;
    assign s_fire  = s_valid && s_ready;
    assign s_idx   = REG_IDX_W'(s_item.dest_register);
    assign a_idx   = REG_IDX_W'(a_item_reg.dest_register);
    assign in_range = 32'(a_item_reg.dest_register) < NUM_DATA_REGS;

    always_comb begin
        unique case (a_item_reg.size_code)
            SZ_BYTE: begin
                mask = 32'h0000_00FF; msb_mask = 32'h0000_0080; width = 6'd8;
                sz_eff = SZ_BYTE;
            end
            SZ_WORD: begin
                mask = 32'h0000_FFFF; msb_mask = 32'h0000_8000; width = 6'd16;
                sz_eff = SZ_WORD;
            end
            default: begin
                mask = 32'hFFFF_FFFF; msb_mask = 32'h8000_0000; width = 6'd32;
                sz_eff = SZ_LONG;
            end
        endcase

        src    = a_item_reg.source_operand & mask;
        d      = a_item_reg.dest_operand & mask;
        cnt    = a_item_reg.source_operand[5:0];
        rot_e  = cnt & (width - 6'd1);
        res    = d;
        cy     = 1'b0;
        ov     = 1'b0;
        tmp    = 32'd0;
        writes = 1'b1;
        fl     = flags_reg;

        case (a_item_reg.action) inside
            ACT_AND: res = src & d;
            ACT_OR:  res = src | d;
            ACT_EOR: res = src ^ d;
            ACT_NOT: res = ~src & mask;
            ACT_NEG: res = (32'd0 - src) & mask;
            ACT_CLR: res = 32'd0;
            ACT_TST: begin
                res    = src;
                writes = 1'b0;
            end
            ACT_ASL, ACT_LSL: begin
                if (cnt != 6'd0) begin
                    res = (cnt < 6'd32) ? ((d << cnt) & mask) : 32'd0;
                    tmp = d >> (width - cnt);
                    cy  = (cnt <= width) && tmp[0];
                    ov  = (a_item_reg.action == ACT_ASL) && (((d ^ res) & msb_mask) != 0);
                end
            end
            ACT_ASR: begin
                if (cnt != 6'd0) begin
                    if (cnt >= width) begin
                        res = ((d & msb_mask) != 0) ? mask : 32'd0;
                    end else begin
                        res = d >> cnt;
                        if ((d & msb_mask) != 0) res = res | (mask & ~(mask >> cnt));
                    end
                    tmp = d >> (cnt - 6'd1);
                    cy  = (cnt <= width) ? tmp[0] : ((d & msb_mask) != 0);
                end
            end
            ACT_LSR: begin
                if (cnt != 6'd0) begin
                    res = (cnt < width) ? (d >> cnt) : 32'd0;
                    tmp = d >> (cnt - 6'd1);
                    cy  = (cnt <= width) && tmp[0];
                end
            end
            ACT_ROL: begin
                if (rot_e != 6'd0) begin
                    res = ((d << rot_e) | (d >> (width - rot_e))) & mask;
                    cy  = res[0];
                end
            end
            ACT_ROR: begin
                if (rot_e != 6'd0) begin
                    res = ((d >> rot_e) | (d << (width - rot_e))) & mask;
                    cy  = (res & msb_mask) != 0;
                end
            end
            default: writes = 1'b0;
        endcase

        if (a_item_reg.action <= ACT_ROR) begin
            fl = 4'd0;
            if (res == 32'd0) fl = fl | FLAG_Z;
            if ((res & msb_mask) != 0) fl = fl | FLAG_N;
            if (ov) fl = fl | FLAG_V;
            if (cy) fl = fl | FLAG_C;
            if (a_item_reg.action == ACT_NEG && res != 32'd0) fl = fl | FLAG_C;
        end

        old_val = fwd_hit_reg ? fwd_data_reg : (rd_valid_reg ? rd_data_reg : 32'd0);
        merged  = (old_val & ~mask) | res;
        reg_wr  = writes && a_item_reg.dest_is_register && in_range;

        out_next               = '0;
        out_next.flags_nzvc    = fl;
        out_next.cycle_total   = cycles_reg + 32'(a_item_reg.instr_cycles);
        if (reg_wr) begin
            out_next.reg_written = 1'b1;
            out_next.reg_value   = merged;
        end
        if (writes && !a_item_reg.dest_is_register) begin
            out_next.mem_write     = 1'b1;
            out_next.mem_address   = a_item_reg.dest_address;
            out_next.mem_value     = res;
            out_next.mem_size_code = sz_eff;
        end
    end

    // RAM write back and registered read
    always_ff @(posedge aclk) begin
        if (a_adv && reg_wr) begin
            regs_mem[a_idx] <= merged;
        end
        if (s_fire) begin
            rd_data_reg <= regs_mem[s_idx];
        end
    end

    // forward a same-cycle write back to the entry being read
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fwd_hit_reg  <= a_adv && reg_wr && (a_idx == s_idx);
            fwd_data_reg <= merged;
            a_item_reg   <= s_item;
        end
        if (a_adv) begin
            m_item_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            a_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            flags_reg      <= 4'd0;
            cycles_reg     <= 32'd0;
        end else begin
            if (s_fire) begin
                rd_valid_reg <= regs_valid_reg[s_idx];
            end
            if (a_adv && reg_wr) begin
                regs_valid_reg[a_idx] <= 1'b1;
            end
            if (a_adv) begin
                flags_reg  <= out_next.flags_nzvc;
                cycles_reg <= out_next.cycle_total;
            end
            if (s_fire) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* test/logic_shift_alu_flags_top_tb.sv */
// Self-checking testbench for logic_shift_alu_flags_top: a directed table, then random items,
// scored against a behavioral model of the execute stage with its own registers and flags.
// Depends on lsaf_pkg and the RTL top level only.
module logic_shift_alu_flags_top_tb
    import lsaf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] ACT_UNKNOWN_MIN = 4'd13;
    localparam logic [3:0] ACT_UNKNOWN_MAX = 4'd15;
    localparam logic [1:0] SZ_RESERVED     = 2'd3;
    localparam int RANDOM_ITEMS = 1950;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIME_LIMIT   = 2_000_000;   // ns

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } directed_row_t;

    localparam out_item_t NONE = '0;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    logic [31:0]   shadow_regs [NUM_DATA_REGS];
    logic [3:0]    kept_flags;
    logic [31:0]   cycle_sum;
    out_item_t     expected_q [$];
    directed_row_t plan [$];
    int            mismatch_count = 0;
    int            burst_left = 0;
    bit            steady_sender = 1'b0;
    bit            hold_req = 1'b0;
    logic [9:0]    rx_tick = '0;

    logic_shift_alu_flags_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(TIME_LIMIT);
        $display("logic_shift_alu_flags_top: mismatch");
        $finish;
    end

    function automatic logic [3:0] nz_flags(input logic [31:0] value, input logic [31:0] msb_mask);
        nz_flags = 4'b0;
        if (value == 32'd0) nz_flags |= FLAG_Z;
        if ((value & msb_mask) != 32'd0) nz_flags |= FLAG_N;
    endfunction

    // Execute one operation on the shadow state and return the result item it must produce.
    function automatic out_item_t alu_predict(input in_item_t it);
        logic [31:0] msk, sgn, srcm, d, res;
        logic [3:0]  fl;
        logic [1:0]  sz;
        logic        cy, ov, writes;
        int unsigned width, cnt, e;
        out_item_t   r;
        r = '0;
        res = '0;
        cy = 1'b0;
        ov = 1'b0;
        writes = 1'b1;
        case (it.size_code)
            SZ_BYTE: begin width = 8;  msk = 32'hFF;       sgn = 32'h80;       sz = SZ_BYTE; end
            SZ_WORD: begin width = 16; msk = 32'hFFFF;     sgn = 32'h8000;     sz = SZ_WORD; end
            default: begin width = 32; msk = 32'hFFFFFFFF; sgn = 32'h80000000; sz = SZ_LONG; end
        endcase
        srcm = it.source_operand & msk;
        d    = it.dest_operand & msk;
        cnt  = it.source_operand[5:0];
        if (it.action <= ACT_TST) begin
            case (it.action)
                ACT_AND: res = srcm & d;
                ACT_OR:  res = srcm | d;
                ACT_EOR: res = srcm ^ d;
                ACT_NOT: res = ~srcm & msk;
                ACT_NEG: res = (32'd0 - srcm) & msk;
                ACT_CLR: res = 32'd0;
                default: begin res = srcm; writes = 1'b0; end
            endcase
            fl = nz_flags(res, sgn);
            if (it.action == ACT_NEG && res != 32'd0) fl |= FLAG_C;
        end else if (it.action <= ACT_ROR) begin
            res = d;
            if (cnt != 0) begin
                case (it.action) inside
                    ACT_ASL, ACT_LSL: begin
                        res = (cnt < 32) ? ((d << cnt) & msk) : 32'd0;
                        if (cnt <= width) cy = ((d >> (width - cnt)) & 32'd1) != 32'd0;
                        if (it.action == ACT_ASL) ov = ((d ^ res) & sgn) != 32'd0;
                    end
                    ACT_ASR: begin
                        if (cnt >= width) begin
                            res = ((d & sgn) != 32'd0) ? msk : 32'd0;
                        end else begin
                            res = d >> cnt;
                            if ((d & sgn) != 32'd0) res |= msk & ~(msk >> cnt);
                        end
                        cy = (cnt <= width) ? (((d >> (cnt - 1)) & 32'd1) != 32'd0)
                                            : ((d & sgn) != 32'd0);
                    end
                    ACT_LSR: begin
                        res = (cnt < width) ? (d >> cnt) : 32'd0;
                        if (cnt <= width) cy = ((d >> (cnt - 1)) & 32'd1) != 32'd0;
                    end
                    default: begin
                        // a count that is a multiple of the width keeps the operand, C clear
                        e = cnt % width;
                        if (e != 0) begin
                            if (it.action == ACT_ROL) begin
                                res = ((d << e) | (d >> (width - e))) & msk;
                                cy  = res[0];
                            end else begin
                                res = ((d >> e) | (d << (width - e))) & msk;
                                cy  = (res & sgn) != 32'd0;
                            end
                        end
                    end
                endcase
            end
            fl = nz_flags(res, sgn);
            if (ov) fl |= FLAG_V;
            if (cy) fl |= FLAG_C;
        end else begin
            writes = 1'b0;
            fl = kept_flags;
        end
        kept_flags = fl;
        cycle_sum  = cycle_sum + it.instr_cycles;
        r.flags_nzvc = fl;
        if (writes) begin
            if (it.dest_is_register) begin
                shadow_regs[it.dest_register] = (shadow_regs[it.dest_register] & ~msk) | res;
                r.reg_written = 1'b1;
                r.reg_value   = shadow_regs[it.dest_register];
            end else begin
                r.mem_write     = 1'b1;
                r.mem_address   = it.dest_address;
                r.mem_value     = res;
                r.mem_size_code = sz;
            end
        end
        r.cycle_total = cycle_sum;
        return r;
    endfunction

    function automatic in_item_t mk_in(input logic [3:0] action, input logic [1:0] size_code,
                                       input logic [31:0] src, input logic [31:0] dst,
                                       input logic to_reg, input logic [2:0] reg_idx,
                                       input logic [23:0] addr, input logic [7:0] cyc);
        in_item_t it;
        it = '{action, size_code, src, dst, to_reg, reg_idx, addr, cyc};
        return it;
    endfunction

    function automatic out_item_t mk_out(input logic [3:0] flags, input logic rw,
                                         input logic [31:0] rv, input logic mw,
                                         input logic [23:0] ma, input logic [31:0] mv,
                                         input logic [1:0] ms, input logic [31:0] total);
        out_item_t r;
        r = '{flags, rw, rv, mw, ma, mv, ms, total};
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFFFFFF;
            2:       return 32'h80;
            3:       return 32'h8000;
            4:       return 32'h80000000;
            5:       return $urandom & 32'hFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned w;
        int unsigned cnt;
        if ($urandom_range(0, 24) == 0)
            it.action = 4'($urandom_range(ACT_UNKNOWN_MIN, ACT_UNKNOWN_MAX));
        else
            it.action = 4'($urandom_range(ACT_AND, ACT_ROR));
        it.size_code = ($urandom_range(0, 15) == 0) ? SZ_RESERVED
                                                   : 2'($urandom_range(SZ_BYTE, SZ_LONG));
        it.source_operand   = pick_operand();
        it.dest_operand     = pick_operand();
        it.dest_is_register = 1'($urandom_range(0, 1));
        it.dest_register    = 3'($urandom);
        it.dest_address     = 24'($urandom);
        it.instr_cycles     = 8'($urandom);
        if (it.action >= ACT_ASL && it.action <= ACT_ROR) begin
            // aim counts at zero and the width boundaries
            w = (it.size_code == SZ_BYTE) ? 8 : (it.size_code == SZ_WORD) ? 16 : 32;
            case ($urandom_range(0, 5))
                0:       cnt = 0;
                1:       cnt = w - 1;
                2:       cnt = w;
                3:       cnt = w + 1;
                4:       cnt = $urandom_range(1, 7);
                default: cnt = $urandom_range(0, 63);
            endcase
            it.source_operand[5:0] = 6'(cnt);
        end
        return it;
    endfunction

    // Present one item in the current burst, wait for the handshake, then predict it.
    task automatic offer(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t predicted;
        @(negedge aclk);
        if (!steady_sender && burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        predicted = alu_predict(it);
        expected_q.push_back(typed ? want : predicted);
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Receiver: cycle through stall patterns, with one long hold on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                rx_tick++;
                case (rx_tick[9:8])
                    2'd0: m_ready <= 1'b1;
                    2'd1: m_ready <= 1'($urandom_range(0, 1));
                    2'd2: m_ready <= (rx_tick[1:0] == 2'd0);
                    2'd3: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t ns: result with no item pending, got %h", $time, m_item);
                mismatch_count++;
            end else begin
                want = expected_q.pop_front();
                if (m_item.flags_nzvc !== want.flags_nzvc)
                    report_field("flags_nzvc", want.flags_nzvc, m_item.flags_nzvc);
                if (m_item.reg_written !== want.reg_written)
                    report_field("reg_written", want.reg_written, m_item.reg_written);
                if (m_item.reg_value !== want.reg_value)
                    report_field("reg_value", want.reg_value, m_item.reg_value);
                if (m_item.mem_write !== want.mem_write)
                    report_field("mem_write", want.mem_write, m_item.mem_write);
                if (m_item.mem_address !== want.mem_address)
                    report_field("mem_address", want.mem_address, m_item.mem_address);
                if (m_item.mem_value !== want.mem_value)
                    report_field("mem_value", want.mem_value, m_item.mem_value);
                if (m_item.mem_size_code !== want.mem_size_code)
                    report_field("mem_size_code", want.mem_size_code, m_item.mem_size_code);
                if (m_item.cycle_total !== want.cycle_total)
                    report_field("cycle_total", want.cycle_total, m_item.cycle_total);
            end
        end
    end

    initial begin
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        kept_flags = '0;
        cycle_sum  = '0;

        // fresh state: test of zero, clear, not into memory, unknown action keeps flags
        plan.push_back('{mk_in(ACT_TST, SZ_BYTE, 32'h0, 32'h0, 1'b1, 3'd0, 24'h0, 8'd5), 1'b1,
                         mk_out(FLAG_Z, 1'b0, 32'h0, 1'b0, 24'h0, 32'h0, SZ_BYTE, 32'd5)});
        plan.push_back('{mk_in(ACT_CLR, SZ_LONG, 32'h12345678, 32'hDEADBEEF, 1'b1, 3'd0, 24'h0,
                               8'd0), 1'b1,
                         mk_out(FLAG_Z, 1'b1, 32'h0, 1'b0, 24'h0, 32'h0, SZ_BYTE, 32'd5)});
        plan.push_back('{mk_in(ACT_NOT, SZ_LONG, 32'h0, 32'h0, 1'b0, 3'd0, 24'hFFFFFF, 8'd255),
                         1'b1, mk_out(FLAG_N, 1'b0, 32'h0, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF,
                                      SZ_LONG, 32'd260)});
        plan.push_back('{mk_in(ACT_UNKNOWN_MAX, SZ_LONG, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 3'd7,
                               24'hFFFFFF, 8'd255), 1'b1,
                         mk_out(FLAG_N, 1'b0, 32'h0, 1'b0, 24'h0, 32'h0, SZ_BYTE, 32'd515)});
        plan.push_back('{mk_in(ACT_CLR, SZ_LONG, 32'h0, 32'h0, 1'b1, 3'd1, 24'h0, 8'd1), 1'b0,
                         NONE});
        plan.push_back('{mk_in(ACT_OR, SZ_LONG, 32'hA5A5A5A5, 32'h0, 1'b1, 3'd1, 24'h0, 8'd1),
                         1'b0, NONE});
        plan.push_back('{mk_in(ACT_AND, SZ_BYTE, 32'hFFFFFFFF, 32'h80, 1'b1, 3'd1, 24'h0, 8'd2),
                         1'b0, NONE});
        plan.push_back('{mk_in(ACT_OR, SZ_WORD, 32'h0, 32'h8000, 1'b0, 3'd0, 24'h123456, 8'd3),
                         1'b0, NONE});
        plan.push_back('{mk_in(ACT_EOR, SZ_LONG, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 3'd7, 24'h0,
                               8'd4), 1'b0, NONE});
        plan.push_back('{mk_in(ACT_NEG, SZ_BYTE, 32'h80, 32'h0, 1'b0, 3'd0, 24'h000001, 8'd4),
                         1'b0, NONE});
        plan.push_back('{mk_in(ACT_NEG, SZ_WORD, 32'hFFFF0000, 32'h0, 1'b1, 3'd2, 24'h0, 8'd4),
                         1'b0, NONE});
        plan.push_back('{mk_in(ACT_TST, SZ_LONG, 32'h80000000, 32'h0, 1'b0, 3'd0, 24'h0, 8'd4),
                         1'b0, NONE});
        // shifts: overflow, count equal to and past the width, zero count
        plan.push_back('{mk_in(ACT_ASL, SZ_BYTE, 32'd1, 32'h40, 1'b1, 3'd3, 24'h0, 8'd6), 1'b0,
                         NONE});
        plan.push_back('{mk_in(ACT_ASL, SZ_BYTE, 32'd8, 32'h01, 1'b1, 3'd3, 24'h0, 8'd6), 1'b0,
                         NONE});
        plan.push_back('{mk_in(ACT_ASL, SZ_WORD, 32'd17, 32'hFFFF, 1'b0, 3'd0, 24'hABCDEF, 8'd6),
                         1'b0, NONE});
        plan.push_back('{mk_in(ACT_ASR, SZ_WORD, 32'hFFFFFFC0, 32'h8000, 1'b1, 3'd4, 24'h0, 8'd6),
                         1'b0, NONE});
        plan.push_back('{mk_in(ACT_ASR, SZ_BYTE, 32'd20, 32'h80, 1'b1, 3'd4, 24'h0, 8'd6), 1'b0,
                         NONE});
        plan.push_back('{mk_in(ACT_LSL, SZ_LONG, 32'd31, 32'h1, 1'b1, 3'd5, 24'h0, 8'd8), 1'b0,
                         NONE});
        plan.push_back('{mk_in(ACT_LSL, SZ_LONG, 32'd32, 32'h1, 1'b0, 3'd0, 24'h000100, 8'd8),
                         1'b0, NONE});
        plan.push_back('{mk_in(ACT_LSR, SZ_WORD, 32'd16, 32'h8000, 1'b1, 3'd6, 24'h0, 8'd8), 1'b0,
                         NONE});
        plan.push_back('{mk_in(ACT_LSR, SZ_LONG, 32'd63, 32'hFFFFFFFF, 1'b1, 3'd6, 24'h0, 8'd8),
                         1'b0, NONE});
        plan.push_back('{mk_in(ACT_ROL, SZ_BYTE, 32'd8, 32'h81, 1'b1, 3'd2, 24'h0, 8'd10), 1'b0,
                         NONE});
        plan.push_back('{mk_in(ACT_ROL, SZ_BYTE, 32'd3, 32'h30, 1'b1, 3'd2, 24'h0, 8'd10), 1'b0,
                         NONE});
        plan.push_back('{mk_in(ACT_ROR, SZ_LONG, 32'd32, 32'h80000001, 1'b0, 3'd0, 24'h0, 8'd10),
                         1'b0, NONE});
        plan.push_back('{mk_in(ACT_ROR, SZ_RESERVED, 32'd33, 32'h1, 1'b0, 3'd0, 24'hFFFF00,
                               8'd10), 1'b0, NONE});

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) offer(plan[i].stim, plan[i].typed, plan[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 900) hold_req = 1'b1;
            steady_sender = (n >= 1400 && n < 1600);
            offer(random_item(), 1'b0, NONE);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("logic_shift_alu_flags_top: match");
        end else begin
            $display("logic_shift_alu_flags_top: mismatch");
        end
        $finish;
    end

endmodule
